>>> design/assert_macros.svh
// Assertion macros for the RTL of the set block, included by the top-level file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clk edge, gated off while rst is high.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check a property on every rising clk edge, reset cycles included.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> design/bis_pkg.sv
// Package for the bounded integer set: operation codes, FSM states, cell control.
`default_nettype none
package bis_pkg;

  localparam int DEF_CAPACITY = 8;
  localparam int VALUE_W      = 32;
  localparam int KIND_W       = 2;
  localparam int COUNT_OUT_W  = 4;
  localparam int IN_DATA_W    = 32;
  localparam int OUT_DATA_W   = 8;

  typedef enum logic [KIND_W-1:0] {
    KIND_INSERT = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_LOOKUP = 2'd2,
    KIND_CLEAR  = 2'd3
  } kind_t;

  typedef enum logic {
    ST_IDLE  = 1'b0,
    ST_APPLY = 1'b1
  } state_t;

  typedef struct packed {
    logic cmp;    // latch compare result against the operand
    logic load;   // write the operand into the entry
    logic shift;  // take the upper neighbor's entry if at or above the hit
  } cell_ctl_t;

endpackage
`default_nettype wire

>>> design/bis_cell.sv
// One storage cell of the set: entry register, compare, and shift-down path.
`default_nettype none
module bis_cell (
  input  logic                         clk,
  input  bis_pkg::cell_ctl_t           ctl,
  input  logic                         live,
  input  logic [bis_pkg::VALUE_W-1:0]  value,
  input  logic                         seen_in,
  output logic                         seen_out,
  input  logic [bis_pkg::VALUE_W-1:0]  shift_data,
  output logic [bis_pkg::VALUE_W-1:0]  entry
);
  import bis_pkg::*;

  logic hit;

  assign seen_out = seen_in | hit;

  always_ff @(posedge clk) begin
    if (ctl.cmp) begin
      hit <= live && (entry == value);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      entry <= value;
    end else if (ctl.shift && seen_out) begin
      entry <= shift_data;
    end
  end

endmodule
`default_nettype wire

>>> design/bounded_integer_set.sv
// Top level of the bounded integer set: handshake, FSM, count, cell chain.
//
//  channel | dir | fields (lowest bit first)
//  s_*     | in  | tuser: kind[1:0]; tdata: value[31:0]
//  m_*     | out | tdata: success[0], was_member[1], count[5:2], zero[7:6]
//
// The accept cycle latches a compare in every cell; the apply state that follows
// resolves the hit chain and updates entries and count.
// A result waiting in the output register does not block acceptance; only an
// update that finds the output register still full holds in the apply state.
// rst clears the count and control; entries are not cleared.
`default_nettype none
`include "assert_macros.svh"
module bounded_integer_set #(
  parameter int CAPACITY = bis_pkg::DEF_CAPACITY
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [bis_pkg::IN_DATA_W-1:0]   s_tdata,   // value[31:0]
  input  logic [bis_pkg::KIND_W-1:0]      s_tuser,   // kind[1:0]
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [bis_pkg::OUT_DATA_W-1:0]  m_tdata    // success, was_member, count[3:0], 0[1:0]
);
  import bis_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);

  state_t             state, state_next;
  kind_t              op_kind;
  logic [VALUE_W-1:0] op_value;
  logic [CW-1:0]      count, count_next;

  logic               s_fire;
  logic               apply_fire;
  logic               member;
  logic               full;
  logic               ok;
  logic               member_out;
  logic               do_load;
  logic               do_shift;
  logic [VALUE_W-1:0] cell_value;

  logic [CAPACITY:0]  seen;
  logic [CAPACITY-1:0] load_vec;
  logic [VALUE_W-1:0] entry [CAPACITY];

  // FSM next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) state_next = ST_APPLY;
      end
      ST_APPLY: begin
        if (!m_tvalid || m_tready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // FSM outputs
  always_comb begin
    s_tready   = 1'b0;
    apply_fire = 1'b0;
    case (state)
      ST_IDLE:  s_tready   = 1'b1;
      ST_APPLY: apply_fire = !m_tvalid || m_tready;
      default: begin
        s_tready   = 1'b0;
        apply_fire = 1'b0;
      end
    endcase
  end

  assign s_fire     = s_tvalid && s_tready;
  assign cell_value = (state == ST_IDLE) ? s_tdata : op_value;
  assign member     = seen[CAPACITY];
  assign full       = (count == CW'(CAPACITY));

  always_comb begin
    ok         = 1'b1;
    member_out = member;
    do_load    = 1'b0;
    do_shift   = 1'b0;
    count_next = count;
    case (op_kind)
      KIND_INSERT: begin
        ok = member || !full;
        if (!member && !full) begin
          do_load    = 1'b1;
          count_next = count + CW'(1);
        end
      end
      KIND_REMOVE: begin
        ok = member;
        if (member) begin
          do_shift   = 1'b1;
          count_next = count - CW'(1);
        end
      end
      KIND_LOOKUP: ok = 1'b1;
      KIND_CLEAR: begin
        member_out = 1'b0;
        count_next = '0;
      end
      default: ok = 1'b1;
    endcase
  end

  assign seen[0] = 1'b0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    cell_ctl_t          ctl;
    logic [VALUE_W-1:0] up_data;

    assign load_vec[i] = apply_fire && do_load && (count == CW'(i));
    assign ctl.cmp     = s_fire;
    assign ctl.load    = load_vec[i];
    assign ctl.shift   = apply_fire && do_shift;

    if (i == CAPACITY - 1) begin : g_last
      assign up_data = entry[i];
    end else begin : g_mid
      assign up_data = entry[i+1];
    end

    bis_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .live       (CW'(i) < count),
      .value      (cell_value),
      .seen_in    (seen[i]),
      .seen_out   (seen[i+1]),
      .shift_data (up_data),
      .entry      (entry[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (apply_fire) begin
        count    <= count_next;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire) begin
      op_kind  <= kind_t'(s_tuser);
      op_value <= s_tdata;
    end
    if (apply_fire) begin
      m_tdata <= {2'b00, COUNT_OUT_W'(count_next), member_out, ok};
    end
  end

  `ASSERT_CLK(a_count_bound, count <= CW'(CAPACITY), "count above capacity")
  `ASSERT_CLK(a_single_load, $onehot0(load_vec), "more than one cell loaded")
  `ASSERT_CLK(a_apply_done, apply_fire |=> (state == ST_IDLE) && m_tvalid, "update not retired")
  `ASSERT_ALWAYS(a_no_accept_busy, (state == ST_APPLY) |-> !s_tready, "accept while busy")

endmodule
`default_nettype wire
